### rtl/core/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
// Used by bba_ctrl, bba_dp and bitmap_block_allocator; no dependencies.
package bba_pkg;

  localparam int MAP_BYTES     = 64;
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_W         = 3;
  localparam int IDX_W         = 9;
  localparam int ADDR_W        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int NUM_GROUPS    = (MAP_BYTES + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
  localparam int GRP_W         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  localparam logic [7:0] FULL_BYTE = 8'hFF;

  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_USE   = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [1:0] operation;
    idx_t       block_index;
  } bba_in_t;

  typedef struct packed {
    idx_t first_free;
    logic none_free;
  } bba_out_t;

  typedef struct packed {
    logic capture;
    logic write_back;
    logic scan_grp;
    logic scan_sel;
    logic fetch;
    logic load_out;
  } bba_cmd_t;

endpackage

### rtl/core/bba_ctrl.sv
// Sequencing state machine of the bitmap block allocator.
// Depends on bba_pkg; drives the command struct into bba_dp.
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output bba_pkg::bba_cmd_t cmd
);
  import bba_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_WRITE    = 6'b000010,
    S_SCAN_GRP = 6'b000100,
    S_SCAN_SEL = 6'b001000,
    S_FETCH    = 6'b010000,
    S_FIND     = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_busy;

  assign out_busy = out_valid && out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_back = 1'b1;
        state_next     = S_SCAN_GRP;
      end
      S_SCAN_GRP: begin
        cmd.scan_grp = 1'b1;
        state_next   = S_SCAN_SEL;
      end
      S_SCAN_SEL: begin
        cmd.scan_sel = 1'b1;
        state_next   = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_FIND;
      end
      S_FIND: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result loaded over a pending transaction");
  a_accept_starts_write: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_WRITE && in_stall))
    else $error("accepted transaction did not start the update");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register not one-hot");
`endif

endmodule

### rtl/core/bba_dp.sv
// Datapath of the bitmap block allocator: map memory, per-byte full flags,
// two-level first-free search and result register. Depends on bba_pkg.
module bba_dp (
  input  logic              clk,
  input  logic              rst,
  input  bba_pkg::bba_cmd_t cmd,
  input  bba_pkg::bba_in_t  in_item,
  output bba_pkg::bba_out_t out_item
);
  import bba_pkg::*;

  logic [7:0]                mem [MAP_BYTES];
  logic [MAP_BYTES-1:0]      valid;
  logic [MAP_BYTES-1:0]      full;

  logic [1:0]                op_q;
  idx_t                      idx_q;
  logic [7:0]                rd_q;
  logic                      rd_vld_q;
  logic [NUM_GROUPS-1:0]     grp_any_q;
  logic [BIT_W-1:0]          grp_pos_q [NUM_GROUPS];
  addr_t                     sel_addr_q;
  logic                      sel_found_q;

  addr_t                     rd_addr;
  addr_t                     wr_addr;
  logic                      in_range;
  logic [7:0]                rd_byte;
  logic [7:0]                bit_mask;
  logic [7:0]                new_byte;
  logic                      do_write;
  logic [NUM_GROUPS*8-1:0]   full_pad;
  logic [NUM_GROUPS-1:0]     grp_any;
  logic [BIT_W-1:0]          grp_pos [NUM_GROUPS];
  logic [GRP_W-1:0]          sel_g;
  logic [BIT_W-1:0]          free_bit;

  assign wr_addr  = addr_t'(idx_q[IDX_W-1:BIT_W]);
  assign in_range = 32'(idx_q[IDX_W-1:BIT_W]) < MAP_BYTES;
  assign rd_addr  = cmd.fetch ? sel_addr_q : addr_t'(in_item.block_index[IDX_W-1:BIT_W]);
  assign rd_byte  = rd_vld_q ? rd_q : 8'h00;
  assign bit_mask = 8'h01 << idx_q[BIT_W-1:0];
  assign new_byte = (op_q == OP_USE) ? (rd_byte | bit_mask) : (rd_byte & ~bit_mask);
  assign do_write = cmd.write_back && in_range && (op_q == OP_USE || op_q == OP_FREE);

  always_comb begin
    full_pad                = '1;
    full_pad[MAP_BYTES-1:0] = full;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_any[g] = ~&full_pad[g*8 +: 8];
      grp_pos[g] = '0;
      for (int j = 7; j >= 0; j--) begin
        if (!full_pad[g*8 + j]) grp_pos[g] = BIT_W'(j);
      end
    end
  end

  always_comb begin
    sel_g = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_any_q[g]) sel_g = GRP_W'(g);
    end
  end

  always_comb begin
    free_bit = '0;
    for (int j = 7; j >= 0; j--) begin
      if (!rd_byte[j]) free_bit = BIT_W'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture || cmd.fetch) begin
      rd_q <= mem[rd_addr];
    end
    if (do_write) begin
      mem[wr_addr] <= new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      full  <= '0;
    end else if (do_write) begin
      valid[wr_addr] <= 1'b1;
      full[wr_addr]  <= (new_byte == FULL_BYTE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= in_item.operation;
      idx_q <= in_item.block_index;
    end
    if (cmd.capture || cmd.fetch) begin
      rd_vld_q <= valid[rd_addr];
    end
    if (cmd.scan_grp) begin
      grp_any_q <= grp_any;
      grp_pos_q <= grp_pos;
    end
    if (cmd.scan_sel) begin
      sel_addr_q  <= addr_t'({sel_g, grp_pos_q[sel_g]});
      sel_found_q <= |grp_any_q;
    end
    if (cmd.load_out) begin
      out_item.first_free <= sel_found_q ? idx_t'({sel_addr_q, free_bit}) : '0;
      out_item.none_free  <= !sel_found_q;
    end
  end

`ifndef SYNTHESIS
  a_full_flag_tracks: assert property (@(posedge clk) disable iff (rst)
    do_write |=> (full[$past(wr_addr)] == ($past(new_byte) == FULL_BYTE)))
    else $error("full flag out of step with written byte");
  a_found_byte_has_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && sel_found_q) |-> (rd_byte != FULL_BYTE))
    else $error("search selected a full byte");
  a_none_free_zero: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load_out) && out_item.none_free |-> (out_item.first_free == '0))
    else $error("none_free with nonzero block number");
`endif

endmodule

### rtl/core/bitmap_block_allocator.sv
// Bitmap block allocator top level: joins bba_ctrl and bba_dp; uses bba_pkg.
// Sequence: after acceptance the update is written back, the two-step search runs
// (group scan, group select), the byte is fetched through the map read port, and
// find loads the result once no prior result waits; input stalls until idle again.
// Reset (rst, synchronous): map reads as all free via per-byte valid bits,
// no wait after reset; control and output valid cleared.
module bitmap_block_allocator (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bba_pkg::bba_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output bba_pkg::bba_out_t out_item
);
  import bba_pkg::*;

  bba_cmd_t cmd;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bba_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

### sim/testbench.sv
// Self-checking testbench for bitmap_block_allocator: mark, free and query transactions
// are scored against a local bitmap that tracks the lowest free block.
// Depends on bba_pkg and the bitmap_block_allocator RTL.
module testbench;
  import bba_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         NUM_BLOCKS  = MAP_BYTES * BITS_PER_BYTE;
  localparam int         HOLD_CYCLES = 300;
  localparam int         LIMIT       = 200000;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  bba_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bba_out_t out_item;

  logic [7:0] usage_map [MAP_BYTES];
  bba_out_t   free_results_q [$];
  idx_t       lowest_free = '0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic       hold_active = 1'b0;
  int         fail_count = 0;
  int         sent_count = 0;
  int         checked_count = 0;
  int         cycle_count = 0;

  bitmap_block_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("[bitmap_block_allocator] ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    out_stall <= hold_active || ($urandom_range(99) < stall_pct);

  function automatic bba_out_t mark_and_find_free(input bba_in_t item);
    int unsigned byte_num;
    logic [2:0]  bit_num;
    bba_out_t    res;
    byte_num = item.block_index / BITS_PER_BYTE;
    bit_num = item.block_index[2:0];
    res = '0;
    res.none_free = 1'b1;
    if (byte_num < MAP_BYTES) begin
      if (item.operation == OP_USE) usage_map[byte_num][bit_num] = 1'b1;
      else if (item.operation == OP_FREE) usage_map[byte_num][bit_num] = 1'b0;
    end
    for (int i = 0; i < MAP_BYTES; i++) begin
      if (res.none_free && usage_map[i] != FULL_BYTE) begin
        for (int j = BITS_PER_BYTE - 1; j >= 0; j--)
          if (!usage_map[i][j]) res.first_free = idx_t'(i * BITS_PER_BYTE + j);
        res.none_free = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic bba_in_t make_item(input logic [1:0] op, input int idx);
    bba_in_t item;
    item.operation = op;
    item.block_index = idx_t'(idx);
    return item;
  endfunction

  // allocator-like traffic: mostly take the lowest free block, release at random
  function automatic bba_in_t pick_item(input int release_pct);
    int r;
    r = $urandom_range(99);
    if (r < release_pct) return make_item(OP_FREE, $urandom_range(NUM_BLOCKS - 1));
    if (r < 85) return make_item(OP_USE, lowest_free);
    if (r < 92) return make_item(OP_USE, $urandom_range(NUM_BLOCKS - 1));
    if (r < 96) return make_item(OP_QUERY, $urandom_range(NUM_BLOCKS - 1));
    return make_item(OP_UNUSED, $urandom_range(NUM_BLOCKS - 1));
  endfunction

  task automatic send_item(input bba_in_t item);
    bba_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = mark_and_find_free(item);
    free_results_q.push_back(res);
    lowest_free = res.first_free;
    sent_count++;
  endtask

  always @(posedge clk) begin : check_results
    bba_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (free_results_q.size() == 0) begin
        $error("unexpected transaction: first_free %0d none_free %0d",
               out_item.first_free, out_item.none_free);
        fail_count++;
      end else begin
        want = free_results_q.pop_front();
        checked_count++;
        if (out_item.first_free !== want.first_free) begin
          $error("first_free: expected %0d, actual %0d", want.first_free, out_item.first_free);
          fail_count++;
        end
        if (out_item.none_free !== want.none_free) begin
          $error("none_free: expected %0d, actual %0d", want.none_free, out_item.none_free);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(make_item(OP_QUERY, 0));
    send_item(make_item(OP_USE, 0));
    send_item(make_item(OP_USE, 1));
    send_item(make_item(OP_USE, 7));
    send_item(make_item(OP_UNUSED, 2));
    for (int b = 2; b < 7; b++) send_item(make_item(OP_USE, b));
    send_item(make_item(OP_USE, 8));
    send_item(make_item(OP_USE, NUM_BLOCKS - 1));
    send_item(make_item(OP_FREE, 3));
    send_item(make_item(OP_USE, 3));
    send_item(make_item(OP_FREE, 0));
    send_item(make_item(OP_FREE, NUM_BLOCKS - 1));
    send_item(make_item(OP_UNUSED, NUM_BLOCKS - 1));
    send_item(make_item(OP_QUERY, NUM_BLOCKS - 1));
    send_item(make_item(OP_FREE, 8));
    send_item(make_item(OP_USE, 0));
    send_item(make_item(OP_FREE, 256));
  endtask

  // mark every block in shuffled order, then poke the all-used map
  task automatic test_full_map();
    int order [NUM_BLOCKS];
    int k;
    int tmp;
    send_idle_pct = 62;
    stall_pct = 0;
    for (int i = 0; i < NUM_BLOCKS; i++) order[i] = i;
    for (int i = NUM_BLOCKS - 1; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    for (int i = 0; i < NUM_BLOCKS; i++) send_item(make_item(OP_USE, order[i]));
    send_item(make_item(OP_QUERY, 0));
    send_item(make_item(OP_UNUSED, 100));
    send_item(make_item(OP_USE, 200));
    send_item(make_item(OP_FREE, NUM_BLOCKS - 1));
    send_item(make_item(OP_USE, NUM_BLOCKS - 1));
    send_item(make_item(OP_FREE, 0));
  endtask

  task automatic test_random_mix(input int idle, input int stall, input int release_pct);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < 200; n++) send_item(pick_item(release_pct));
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end
      for (int n = 0; n < 80; n++) send_item(pick_item(30));
    join
  endtask

  initial begin
    foreach (usage_map[i]) usage_map[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_map();
    test_random_mix(0, 0, 50);
    test_random_mix(62, 0, 30);
    test_random_mix(0, 62, 15);
    test_random_mix(19, 19, 30);
    test_output_hold();
    in_valid <= 1'b0;
    while (free_results_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results: directed marks, full map,",
             sent_count, checked_count);
    $display("random alloc/free mixes under four idle patterns and a long output hold-off.");
    if (fail_count == 0) begin
      $display("[bitmap_block_allocator] OK");
    end else begin
      $display("[bitmap_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
